// ===== hdl/brl_pkg.sv =====
`default_nettype none

package brl_pkg;

	localparam int SCREEN_SIZE = 64;
	localparam int COORD_W     = $clog2(SCREEN_SIZE);
	// Decision variable: two coordinate differences doubled, plus sign and headroom
	localparam int D_W         = COORD_W + 4;
	localparam int COLOR_W     = 24;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic load;
		logic step;
	} brl_cmd_t;

	typedef struct packed {
		logic walk_done;
	} brl_status_t;

	// Saturate a coordinate to the last pixel of the screen
	function automatic coord_t clamp_coord(input coord_t v);
		coord_t lim;
		lim = COORD_W'(SCREEN_SIZE - 1);
		return (v > lim) ? lim : v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/brl_ctrl.sv =====
`default_nettype none

module brl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              seg_valid,
	output logic                   seg_stall,
	output logic                   pix_valid,
	input  wire logic              pix_stall,
	input  wire brl_pkg::brl_status_t status,
	output brl_pkg::brl_cmd_t      cmd
);
	import brl_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic pix_valid_q;
	logic slot_free;

	assign slot_free = !pix_valid_q || !pix_stall;
	assign seg_stall = (state_q != ST_IDLE);
	assign pix_valid = pix_valid_q;

	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		case (state_q)
			ST_IDLE: cmd.load = seg_valid;
			ST_BUSY: cmd.step = slot_free;
			default: begin
				cmd.load = 1'b0;
				cmd.step = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (seg_valid) state_q <= ST_BUSY;
				ST_BUSY: if (slot_free && status.walk_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.step) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/brl_datapath.sv =====
`default_nettype none

module brl_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire brl_pkg::brl_cmd_t    cmd,
	output brl_pkg::brl_status_t      status,
	input  wire brl_pkg::coord_t      start_x,
	input  wire brl_pkg::coord_t      start_y,
	input  wire brl_pkg::coord_t      end_x,
	input  wire brl_pkg::coord_t      end_y,
	input  wire logic                 cfg_wr,
	input  wire brl_pkg::color_t      cfg_color,
	output brl_pkg::coord_t           pixel_x,
	output brl_pkg::coord_t           pixel_y,
	output brl_pkg::color_t           pixel_color,
	output logic                      last_pixel
);
	import brl_pkg::*;

	coord_t sx, sy, ex, ey;
	coord_t x0, y0, x1, y1;
	logic [COORD_W:0] dx, ady;
	logic signed [COORD_W:0] dy;
	logic signed [D_W-1:0] dy_ext, dx_ext, d_init;
	logic major_y, y_pos;

	coord_t x_q, y_q, x1_q, y1_q;
	logic signed [D_W-1:0] d_q, two_dy_q, two_dx_q, d_next;
	logic major_y_q, y_pos_q;
	coord_t x_next, y_next;
	color_t color_q;

	coord_t pix_x_q, pix_y_q;
	color_t pix_color_q;
	logic   pix_last_q;

	// Order the endpoints left to right; a vertical segment keeps its order
	always_comb begin
		sx = clamp_coord(start_x);
		sy = clamp_coord(start_y);
		ex = clamp_coord(end_x);
		ey = clamp_coord(end_y);
		if (sx > ex) begin
			x0 = ex; y0 = ey; x1 = sx; y1 = sy;
		end else begin
			x0 = sx; y0 = sy; x1 = ex; y1 = ey;
		end
		dx      = {1'b0, x1} - {1'b0, x0};
		dy      = $signed({1'b0, y1}) - $signed({1'b0, y0});
		ady     = dy[COORD_W] ? (COORD_W+1)'(0) - dy : dy;
		major_y = ady > dx;
		y_pos   = !dy[COORD_W] && (dy != '0);
		dy_ext  = {{(D_W-COORD_W-1){dy[COORD_W]}}, dy};
		dx_ext  = {{(D_W-COORD_W-1){1'b0}}, dx};
		case ({major_y, y_pos})
			2'b01:   d_init = dy_ext + dy_ext - dx_ext;
			2'b00:   d_init = dy_ext + dy_ext + dx_ext;
			2'b11:   d_init = dy_ext - dx_ext - dx_ext;
			default: d_init = dy_ext + dx_ext + dx_ext;
		endcase
	end

	assign status.walk_done = major_y_q ? (y_q == y1_q) : (x_q == x1_q);

	// One step of the four-octant walk
	always_comb begin
		x_next = x_q;
		y_next = y_q;
		d_next = d_q;
		case ({major_y_q, y_pos_q})
			2'b01: begin
				x_next = x_q + COORD_W'(1);
				if (d_q > 0) begin
					y_next = y_q + COORD_W'(1);
					d_next = d_q + two_dy_q - two_dx_q;
				end else begin
					d_next = d_q + two_dy_q;
				end
			end
			2'b00: begin
				x_next = x_q + COORD_W'(1);
				if (d_q < 0) begin
					y_next = y_q - COORD_W'(1);
					d_next = d_q + two_dy_q + two_dx_q;
				end else begin
					d_next = d_q + two_dy_q;
				end
			end
			2'b11: begin
				y_next = y_q + COORD_W'(1);
				if (d_q < 0) begin
					x_next = x_q + COORD_W'(1);
					d_next = d_q + two_dy_q - two_dx_q;
				end else begin
					d_next = d_q - two_dx_q;
				end
			end
			default: begin
				y_next = y_q - COORD_W'(1);
				if (d_q > 0) begin
					x_next = x_q + COORD_W'(1);
					d_next = d_q + two_dy_q + two_dx_q;
				end else begin
					d_next = d_q + two_dx_q;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg_wr) begin
			color_q <= cfg_color;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q       <= x0;
			y_q       <= y0;
			x1_q      <= x1;
			y1_q      <= y1;
			d_q       <= d_init;
			two_dy_q  <= dy_ext + dy_ext;
			two_dx_q  <= dx_ext + dx_ext;
			major_y_q <= major_y;
			y_pos_q   <= y_pos;
		end else if (cmd.step && !status.walk_done) begin
			x_q <= x_next;
			y_q <= y_next;
			d_q <= d_next;
		end
		if (cmd.step) begin
			pix_x_q     <= status.walk_done ? x1_q : x_q;
			pix_y_q     <= status.walk_done ? y1_q : y_q;
			pix_last_q  <= status.walk_done;
			pix_color_q <= color_q;
		end
	end

	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = pix_last_q;

endmodule

`default_nettype wire

// ===== hdl/bresenham_line_rasterizer.sv =====
`default_nettype none

// Line rasteriser: takes one segment (start_x/start_y, end_x/end_y) per transaction
// and returns one transaction per pixel, walking left to right with an integer
// Bresenham decision variable; vertical segments run from the start toward the end.
// The exact end point is always the final pixel and carries last_pixel. A segment
// produces (longer axis length + 1) pixels, one per cycle while the pixel side does
// not stall, and a new segment is taken only once the walk of the previous one has
// reached its end point; the walk unit advances one pixel per cycle while the pixel
// side does not stall. The final pixel may still wait in the output register
// when the next segment is accepted. Every pixel carries draw_color; write it only
// while no segment is in flight. draw_color resets to zero.
module bresenham_line_rasterizer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Segment channel
	input  wire logic             seg_valid,
	output logic                  seg_stall,
	input  wire brl_pkg::coord_t  start_x,
	input  wire brl_pkg::coord_t  start_y,
	input  wire brl_pkg::coord_t  end_x,
	input  wire brl_pkg::coord_t  end_y,
	// Pixel channel
	output logic                  pix_valid,
	input  wire logic             pix_stall,
	output brl_pkg::coord_t       pixel_x,
	output brl_pkg::coord_t       pixel_y,
	output brl_pkg::color_t       pixel_color,
	output logic                  last_pixel,
	// Colour register write channel
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire brl_pkg::color_t  draw_color
);
	import brl_pkg::*;

	brl_cmd_t    cmd;
	brl_status_t status;

	// Always take colour writes; they land in a single register
	assign cfg_ready = 1'b1;

	brl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.status    (status),
		.cmd       (cmd)
	);

	brl_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_color   (draw_color),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule

`default_nettype wire
